// ===== sv/ucw_pkg.sv =====
// ----------------------------------------------------------------------------
// ucw_pkg
// Shared words, stage records and constant tables of the character width core
// ----------------------------------------------------------------------------
`default_nettype none

package ucw_pkg;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } in_word_t;

  typedef struct packed {
    logic signed [2:0] width;
    logic [2:0]        byte_length;
    logic [20:0]       code_point;
    logic              bad_lead;
  } out_word_t;

  localparam int ZW_COUNT     = 100;
  localparam int ZW_GROUPS    = 10;
  localparam int ZW_PER_GROUP = ZW_COUNT / ZW_GROUPS;

  // decode stage result
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_length;
    logic        bad_lead;
  } dec_t;

  // classify stage result
  typedef struct packed {
    dec_t                 dec;
    logic [ZW_GROUPS-1:0] zw_grp;
    logic                 is_nul;
    logic                 is_ctrl;
    logic                 is_wide;
  } cls_t;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  localparam logic signed [2:0] W_CTRL = -3'sd1;
  localparam logic signed [2:0] W_ZERO = 3'sd0;
  localparam logic signed [2:0] W_ONE  = 3'sd1;
  localparam logic signed [2:0] W_TWO  = 3'sd2;

  localparam logic [20:0] CP_MAX      = 21'h10ffff;
  localparam logic [20:0] CP_C0_END   = 21'h00001f;
  localparam logic [20:0] CP_DEL      = 21'h00007f;
  localparam logic [20:0] CP_C1_END   = 21'h00009f;
  localparam logic [20:0] CP_WIDE_MIN = 21'h001100;
  localparam logic [20:0] CP_WIDE_HI  = 21'h00115f;
  localparam logic [20:0] CP_CJK_LO   = 21'h002e80;
  localparam logic [20:0] CP_CJK_HI   = 21'h00a4cf;
  localparam logic [20:0] CP_CJK_MASK = ~21'h000011;
  localparam logic [20:0] CP_CJK_PUNC = 21'h00300a;
  localparam logic [20:0] CP_CJK_HALF = 21'h00303f;
  localparam logic [20:0] CP_HANG_LO  = 21'h00ac00;
  localparam logic [20:0] CP_HANG_HI  = 21'h00d7a3;
  localparam logic [20:0] CP_CMP_LO   = 21'h00f900;
  localparam logic [20:0] CP_CMP_HI   = 21'h00faff;
  localparam logic [20:0] CP_VERT_LO  = 21'h00fe30;
  localparam logic [20:0] CP_VERT_HI  = 21'h00fe6f;
  localparam logic [20:0] CP_FULL_LO  = 21'h00ff00;
  localparam logic [20:0] CP_FULL_HI  = 21'h00ff5f;
  localparam logic [20:0] CP_SIGN_LO  = 21'h00ffe0;
  localparam logic [20:0] CP_SIGN_HI  = 21'h00ffe6;
  localparam logic [20:0] CP_SIP_LO   = 21'h020000;
  localparam logic [20:0] CP_SIP_HI   = 21'h02ffff;

  // zero-width intervals, lower bounds
  localparam logic [15:0] ZW_LO [ZW_COUNT] = '{
    16'h0300, 16'h0360, 16'h0483, 16'h0488, 16'h0591, 16'h05A3, 16'h05BB, 16'h05BF,
    16'h05C1, 16'h05C4, 16'h064B, 16'h0670, 16'h06D6, 16'h06E7, 16'h06EA, 16'h070F,
    16'h0711, 16'h0730, 16'h07A6, 16'h0901, 16'h093C, 16'h0941, 16'h094D, 16'h0951,
    16'h0962, 16'h0981, 16'h09BC, 16'h09C1, 16'h09CD, 16'h09E2, 16'h0A02, 16'h0A3C,
    16'h0A41, 16'h0A47, 16'h0A4B, 16'h0A70, 16'h0A81, 16'h0ABC, 16'h0AC1, 16'h0AC7,
    16'h0ACD, 16'h0B01, 16'h0B3C, 16'h0B3F, 16'h0B41, 16'h0B4D, 16'h0B56, 16'h0B82,
    16'h0BC0, 16'h0BCD, 16'h0C3E, 16'h0C46, 16'h0C4A, 16'h0C55, 16'h0CBF, 16'h0CC6,
    16'h0CCC, 16'h0D41, 16'h0D4D, 16'h0DCA, 16'h0DD2, 16'h0DD6, 16'h0E31, 16'h0E34,
    16'h0E47, 16'h0EB1, 16'h0EB4, 16'h0EBB, 16'h0EC8, 16'h0F18, 16'h0F35, 16'h0F37,
    16'h0F39, 16'h0F71, 16'h0F80, 16'h0F86, 16'h0F90, 16'h0F99, 16'h0FC6, 16'h102D,
    16'h1032, 16'h1036, 16'h1039, 16'h1058, 16'h1160, 16'h17B7, 16'h17C6, 16'h17C9,
    16'h180B, 16'h18A9, 16'h200B, 16'h202A, 16'h206A, 16'h20D0, 16'h302A, 16'h3099,
    16'hFB1E, 16'hFE20, 16'hFEFF, 16'hFFF9
  };

  // zero-width intervals, upper bounds
  localparam logic [15:0] ZW_HI [ZW_COUNT] = '{
    16'h034E, 16'h0362, 16'h0486, 16'h0489, 16'h05A1, 16'h05B9, 16'h05BD, 16'h05BF,
    16'h05C2, 16'h05C4, 16'h0655, 16'h0670, 16'h06E4, 16'h06E8, 16'h06ED, 16'h070F,
    16'h0711, 16'h074A, 16'h07B0, 16'h0902, 16'h093C, 16'h0948, 16'h094D, 16'h0954,
    16'h0963, 16'h0981, 16'h09BC, 16'h09C4, 16'h09CD, 16'h09E3, 16'h0A02, 16'h0A3C,
    16'h0A42, 16'h0A48, 16'h0A4D, 16'h0A71, 16'h0A82, 16'h0ABC, 16'h0AC5, 16'h0AC8,
    16'h0ACD, 16'h0B01, 16'h0B3C, 16'h0B3F, 16'h0B43, 16'h0B4D, 16'h0B56, 16'h0B82,
    16'h0BC0, 16'h0BCD, 16'h0C40, 16'h0C48, 16'h0C4D, 16'h0C56, 16'h0CBF, 16'h0CC6,
    16'h0CCD, 16'h0D43, 16'h0D4D, 16'h0DCA, 16'h0DD4, 16'h0DD6, 16'h0E31, 16'h0E3A,
    16'h0E4E, 16'h0EB1, 16'h0EB9, 16'h0EBC, 16'h0ECD, 16'h0F19, 16'h0F35, 16'h0F37,
    16'h0F39, 16'h0F7E, 16'h0F84, 16'h0F87, 16'h0F97, 16'h0FBC, 16'h0FC6, 16'h1030,
    16'h1032, 16'h1037, 16'h1039, 16'h1059, 16'h11FF, 16'h17BD, 16'h17C6, 16'h17D3,
    16'h180E, 16'h18A9, 16'h200F, 16'h202E, 16'h206F, 16'h20E3, 16'h302F, 16'h309A,
    16'hFB1E, 16'hFE23, 16'hFEFF, 16'hFFFB
  };

endpackage

`default_nettype wire

// ===== sv/utf8_char_display_width_core.sv =====
// ----------------------------------------------------------------------------
// utf8_char_display_width_core
// Terminal column width of one UTF-8 character per word
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries the four bytes of one
// character, lead byte in byte0. Output channel out_valid/out_ready/out_data
// returns width, byte length, decoded code point and the bad lead flag, one
// result word per input word, in order.
// Pipeline: three register stages (decode, table compare, width resolve), the
// first loaded at the input accept edge; out_valid is high once the word sits in
// the third. Throughput: one word per cycle while the output is not stalled.
// All three stages advance together on one enable; the last stage is the
// output register, so in_ready is low only while a result sits in it and
// out_ready is low. A stalled receiver freezes the whole pipeline with
// nothing dropped or repeated.
// Reset (rst_n low, synchronous) clears the stage valid bits; the stage data
// registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_char_display_width_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ucw_pkg::in_word_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      ucw_pkg::out_word_t out_data
);

  logic          advance;
  logic          v1_r, v2_r, v3_r;
  logic          v1_nxt, v2_nxt, v3_nxt;
  ucw_pkg::dec_t dec;
  ucw_pkg::cls_t cls;

  assign advance   = !v3_r || out_ready;
  assign in_ready  = advance;
  assign out_valid = v3_r;

  assign v1_nxt = advance ? in_valid : v1_r;
  assign v2_nxt = advance ? v1_r     : v2_r;
  assign v3_nxt = advance ? v2_r     : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  ucw_decode u_decode (
    .clk     (clk),
    .en      (advance),
    .in_data (in_data),
    .dec_r   (dec)
  );

  ucw_classify u_classify (
    .clk   (clk),
    .en    (advance),
    .dec   (dec),
    .cls_r (cls)
  );

  ucw_resolve u_resolve (
    .clk   (clk),
    .en    (advance),
    .cls   (cls),
    .out_r (out_data)
  );

`ifndef SYNTHESIS
  // a bad lead always resolves to a control width with empty code point
  a_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_lead |->
      out_data.width == ucw_pkg::W_CTRL && out_data.code_point == 21'd0 &&
      out_data.byte_length == ucw_pkg::LEN_1)
    else $error("bad lead word with wrong fields");

  // double width only from the start of the first wide range up to the code space maximum
  a_wide_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.width == ucw_pkg::W_TWO |->
      out_data.code_point >= ucw_pkg::CP_WIDE_MIN && out_data.code_point <= ucw_pkg::CP_MAX)
    else $error("wide result outside wide code space");

  // stall keeps the words in flight
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> v1_r == $past(v1_r) && v2_r == $past(v2_r) && v3_r)
    else $error("pipeline lost a word under stall");

  // a word in stage two reaches the output stage on the next advance
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    advance && v2_r |=> v3_r)
    else $error("word dropped between stages");
`endif

endmodule

`default_nettype wire

// ===== sv/ucw_decode.sv =====
// ----------------------------------------------------------------------------
// ucw_decode
// Stage 1: lead byte pattern match and code point assembly
// ----------------------------------------------------------------------------
`default_nettype none

module ucw_decode (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire ucw_pkg::in_word_t in_data,
  output ucw_pkg::dec_t        dec_r
);

  ucw_pkg::dec_t dec_nxt;
  logic [7:0]    b0;
  logic [5:0]    b1;
  logic [5:0]    b2;
  logic [5:0]    b3;

  assign b0 = in_data.byte0;
  assign b1 = in_data.byte1[5:0];
  assign b2 = in_data.byte2[5:0];
  assign b3 = in_data.byte3[5:0];

  always_comb begin
    dec_nxt = '0;
    priority if (b0[7] == 1'b0) begin
      dec_nxt.code_point  = {13'd0, b0};
      dec_nxt.byte_length = ucw_pkg::LEN_1;
    end else if (b0[7:5] == 3'b110) begin
      dec_nxt.code_point  = {10'd0, b0[4:0], b1};
      dec_nxt.byte_length = ucw_pkg::LEN_2;
    end else if (b0[7:4] == 4'b1110) begin
      dec_nxt.code_point  = {5'd0, b0[3:0], b1, b2};
      dec_nxt.byte_length = ucw_pkg::LEN_3;
    end else if (b0[7:3] == 5'b11110) begin
      dec_nxt.code_point  = {b0[2:0], b1, b2, b3};
      dec_nxt.byte_length = ucw_pkg::LEN_4;
    end else begin
      // continuation byte or 0xf8 and up as lead
      dec_nxt.byte_length = ucw_pkg::LEN_1;
      dec_nxt.bad_lead    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucw_classify.sv =====
// ----------------------------------------------------------------------------
// ucw_classify
// Stage 2: interval compares against the zero-width table, range flags
// ----------------------------------------------------------------------------
`default_nettype none

module ucw_classify (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ucw_pkg::dec_t dec,
  output ucw_pkg::cls_t      cls_r
);

  ucw_pkg::cls_t               cls_nxt;
  logic [ucw_pkg::ZW_COUNT-1:0] hit;
  logic [20:0]                 cp;
  logic                        bmp;

  assign cp  = dec.code_point;
  assign bmp = (cp[20:16] == 5'd0);

  always_comb begin
    for (int k = 0; k < ucw_pkg::ZW_COUNT; k++) begin
      hit[k] = bmp && (cp[15:0] >= ucw_pkg::ZW_LO[k]) && (cp[15:0] <= ucw_pkg::ZW_HI[k]);
    end
  end

  always_comb begin
    cls_nxt     = '0;
    cls_nxt.dec = dec;
    // first level of the or tree, finished in the next stage
    for (int g = 0; g < ucw_pkg::ZW_GROUPS; g++) begin
      cls_nxt.zw_grp[g] = |hit[g*ucw_pkg::ZW_PER_GROUP +: ucw_pkg::ZW_PER_GROUP];
    end
    cls_nxt.is_nul  = (cp == 21'd0);
    cls_nxt.is_ctrl = (cp <= ucw_pkg::CP_C0_END) ||
                      (cp >= ucw_pkg::CP_DEL && cp <= ucw_pkg::CP_C1_END) ||
                      (cp > ucw_pkg::CP_MAX);
    cls_nxt.is_wide = (cp >= ucw_pkg::CP_WIDE_MIN) &&
                      ((cp <= ucw_pkg::CP_WIDE_HI) ||
                       (cp >= ucw_pkg::CP_CJK_LO && cp <= ucw_pkg::CP_CJK_HI &&
                        (cp & ucw_pkg::CP_CJK_MASK) != ucw_pkg::CP_CJK_PUNC &&
                        cp != ucw_pkg::CP_CJK_HALF) ||
                       (cp >= ucw_pkg::CP_HANG_LO && cp <= ucw_pkg::CP_HANG_HI) ||
                       (cp >= ucw_pkg::CP_CMP_LO  && cp <= ucw_pkg::CP_CMP_HI)  ||
                       (cp >= ucw_pkg::CP_VERT_LO && cp <= ucw_pkg::CP_VERT_HI) ||
                       (cp >= ucw_pkg::CP_FULL_LO && cp <= ucw_pkg::CP_FULL_HI) ||
                       (cp >= ucw_pkg::CP_SIGN_LO && cp <= ucw_pkg::CP_SIGN_HI) ||
                       (cp >= ucw_pkg::CP_SIP_LO  && cp <= ucw_pkg::CP_SIP_HI));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucw_resolve.sv =====
// ----------------------------------------------------------------------------
// ucw_resolve
// Stage 3: width priority resolution into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module ucw_resolve (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ucw_pkg::cls_t cls,
  output ucw_pkg::out_word_t out_r
);

  ucw_pkg::out_word_t out_nxt;
  logic               zw;

  assign zw = |cls.zw_grp;

  always_comb begin
    out_nxt.byte_length = cls.dec.byte_length;
    out_nxt.code_point  = cls.dec.code_point;
    out_nxt.bad_lead    = cls.dec.bad_lead;
    // order matters: a bad lead decodes to zero but is not a nul
    priority if (cls.dec.bad_lead) begin
      out_nxt.width = ucw_pkg::W_CTRL;
    end else if (cls.is_nul) begin
      out_nxt.width = ucw_pkg::W_ZERO;
    end else if (cls.is_ctrl) begin
      out_nxt.width = ucw_pkg::W_CTRL;
    end else if (zw) begin
      out_nxt.width = ucw_pkg::W_ZERO;
    end else if (cls.is_wide) begin
      out_nxt.width = ucw_pkg::W_TWO;
    end else begin
      out_nxt.width = ucw_pkg::W_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
